[rtl/core/adj_matrix_bfs_dfs_traversal_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency matrix traversal block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADJ_MATRIX_BFS_DFS_TRAVERSAL_ASSERT_SVH
`define ADJ_MATRIX_BFS_DFS_TRAVERSAL_ASSERT_SVH

`ifndef ASSERT_OFF

// general property check
`define AT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen
`define AT_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define AT_ASSERT(lbl, prop, msg)
`define AT_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[rtl/core/adjtrav_pkg.sv]
// ----------------------------------------------------------------------------
// adjtrav_pkg
// Shared widths, item mode codes and the engine/result handshake structs.
// ----------------------------------------------------------------------------
package adjtrav_pkg;

	localparam int VW     = 4;   // vertex index width
	localparam int ROW_W  = 16;  // adjacency row width
	localparam int CNT_W  = 5;   // vertex count width (0..16)
	localparam int QDEPTH = 16;  // breadth-first queue entries

	localparam logic [CNT_W-1:0] VCOUNT_RESET = 5'd16;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_BFS  = 2'd1,
		MODE_DFS  = 2'd2
	} mode_e;

	// request from the engine to the result stage
	typedef struct packed {
		logic          emit;    // new vertex found
		logic          flush;   // search over, release held vertex as last
		logic [VW-1:0] vertex;
	} emit_req_t;

	// result stage status back to the engine
	typedef struct packed {
		logic room;        // an emit can be taken this cycle
		logic out_free;    // output register free or draining
		logic pend_valid;  // a vertex is held back awaiting its last flag
	} res_status_t;

endpackage

[rtl/core/adjtrav_ram.sv]
// ----------------------------------------------------------------------------
// adjtrav_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module adjtrav_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/adjtrav_result.sv]
// ----------------------------------------------------------------------------
// adjtrav_result
// Holds the most recent vertex back by one so the final one of a search
// can carry the last flag, and drives the output register.
// ----------------------------------------------------------------------------
`include "adj_matrix_bfs_dfs_traversal_assert.svh"

module adjtrav_result
	import adjtrav_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  emit_req_t     req,
	output res_status_t   status,
	input  logic          result_stall,
	output logic          result_valid,
	output logic [VW-1:0] visited_vertex,
	output logic          last
);

	logic          pend_valid_q;
	logic [VW-1:0] pend_vertex_q;
	logic          out_valid_q;
	logic [VW-1:0] out_vertex_q;
	logic          out_last_q;
	logic          out_free;
	logic          load_out;

	assign out_free = !out_valid_q || !result_stall;
	assign load_out = (req.emit && pend_valid_q) || req.flush;

	assign status.room       = !pend_valid_q || out_free;
	assign status.out_free   = out_free;
	assign status.pend_valid = pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (req.emit) begin
				pend_valid_q <= 1'b1;
			end else if (req.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.emit) begin
			pend_vertex_q <= req.vertex;
		end
		if (load_out) begin
			out_vertex_q <= pend_vertex_q;
			out_last_q   <= req.flush;
		end
	end

	assign result_valid   = out_valid_q;
	assign visited_vertex = out_vertex_q;
	assign last           = out_last_q;

	`AT_ASSERT(a_flush_has_pending, req.flush |-> pend_valid_q, "flush with nothing held")
	`AT_ASSERT(a_no_overrun, load_out |-> out_free, "output register overwritten")
	`AT_ASSERT_NEVER(a_emit_flush, req.emit && req.flush, "emit and flush together")

endmodule

[rtl/core/adj_matrix_bfs_dfs_traversal.sv]
// ----------------------------------------------------------------------------
// adj_matrix_bfs_dfs_traversal
// Breadth-first / depth-first traversal over a bit adjacency matrix.
// ----------------------------------------------------------------------------
// A load item writes one matrix row and gives no result. A search item
// whose start vertex is below the vertex count in use streams the visited
// vertices, the final one flagged last. Each vertex taken from the queue
// costs a dequeue step, then rows 0..vertex_count-1 of the adjacency RAM
// read through its one read port, one row per cycle unless a breadth-first
// find waits for room in the result stage, then a check of the last row
// and a close of the scan. A depth-first vertex also costs a pop step, and
// a pop of an already visited vertex is dropped after that step. A held
// result output stretches either kind of search.
// Only one item is in work at a time; the input stalls from acceptance of a
// search until its last result sits in the output register. There is no
// clearing pass after reset: every row must be loaded before a search
// reads it.
`include "adj_matrix_bfs_dfs_traversal_assert.svh"

module adj_matrix_bfs_dfs_traversal
	import adjtrav_pkg::*;
#(
	parameter int MAX_VERTICES = 16,
	parameter int STACK_DEPTH  = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic [1:0]       mode,
	input  logic [VW-1:0]    vertex,
	input  logic [ROW_W-1:0] row_bits,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [VW-1:0]    visited_vertex,
	output logic             last
);

	localparam int LIMIT  = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
	localparam int ADJ_AW = $clog2(MAX_VERTICES);
	localparam int SAW    = $clog2(STACK_DEPTH);
	localparam int SPW    = $clog2(STACK_DEPTH + 1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_NEXT  = 6'b000100,
		ST_POP   = 6'b001000,
		ST_SCAN  = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] vcount_q;
	logic [CNT_W-1:0] n_q;
	logic             dfs_q;
	logic [VW-1:0]    cur_v_q;
	logic [ROW_W-1:0] marks_q;
	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] tail_q;
	logic [VW-1:0]    queue_q [QDEPTH];
	logic [SPW-1:0]   sp_q;
	logic [CNT_W-1:0] issue_q;
	logic             scan_valid_s1;
	logic [VW-1:0]    scan_i_s1;

	logic             accept;
	logic             is_search;
	logic [CNT_W-1:0] n_eff;
	logic             start_ok;
	logic [SPW-1:0]   sp_dec;
	logic             hit;
	logic             freeze;
	logic             issue_go;
	logic             push;
	logic             scan_done;
	logic             q_we;
	logic [VW-1:0]    q_waddr;
	logic [VW-1:0]    q_wdata;

	logic              adj_we;
	logic [ADJ_AW-1:0] adj_waddr;
	logic [ADJ_AW-1:0] adj_raddr;
	logic [ROW_W-1:0]  adj_rdata;
	logic              stk_we;
	logic [SAW-1:0]    stk_waddr;
	logic [VW-1:0]     stk_wdata;
	logic              stk_re;
	logic [SAW-1:0]    stk_raddr;
	logic [VW-1:0]     pop_v;

	emit_req_t   res_req;
	res_status_t res_st;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign is_search  = (mode == MODE_BFS) || (mode == MODE_DFS);

	// count in use, saturated to the vertex limit
	assign n_eff    = (vcount_q > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : vcount_q;
	assign start_ok = ({1'b0, vertex} < n_eff);
	assign sp_dec   = sp_q - SPW'(1);

	// column scan: row issued one cycle, bit checked in s1 the next
	assign hit       = scan_valid_s1 && adj_rdata[cur_v_q] && !marks_q[scan_i_s1];
	assign freeze    = (state_q == ST_SCAN) && !dfs_q && hit && !res_st.room;
	assign issue_go  = (state_q == ST_SCAN) && !freeze && (issue_q < n_q);
	assign push      = (state_q == ST_SCAN) && dfs_q && hit && (sp_q < SPW'(STACK_DEPTH));
	assign scan_done = (issue_q == n_q) && !scan_valid_s1;

	assign adj_we    = accept && (mode == MODE_LOAD) && (32'(vertex) < MAX_VERTICES);
	assign adj_waddr = ADJ_AW'(vertex);
	assign adj_raddr = ADJ_AW'(issue_q[VW-1:0]);

	assign stk_we    = ((state_q == ST_START) && dfs_q) || push;
	assign stk_waddr = (state_q == ST_START) ? '0 : sp_q[SAW-1:0];
	assign stk_wdata = (state_q == ST_START) ? cur_v_q : scan_i_s1;
	assign stk_re    = (state_q == ST_NEXT) && dfs_q && (sp_q != '0);
	assign stk_raddr = sp_dec[SAW-1:0];

	always_comb begin
		res_req = '0;
		q_we    = 1'b0;
		q_waddr = tail_q[VW-1:0];
		q_wdata = scan_i_s1;
		unique case (state_q)
			ST_START: begin
				if (!dfs_q && res_st.room) begin
					res_req.emit   = 1'b1;
					res_req.vertex = cur_v_q;
					q_we           = 1'b1;
					q_waddr        = '0;
					q_wdata        = cur_v_q;
				end
			end
			ST_POP: begin
				if (!marks_q[pop_v] && res_st.room) begin
					res_req.emit   = 1'b1;
					res_req.vertex = pop_v;
				end
			end
			ST_SCAN: begin
				if (!dfs_q && hit && res_st.room) begin
					res_req.emit   = 1'b1;
					res_req.vertex = scan_i_s1;
					q_we           = 1'b1;
				end
			end
			ST_FLUSH: begin
				res_req.flush = res_st.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			vcount_q      <= VCOUNT_RESET;
			n_q           <= '0;
			dfs_q         <= 1'b0;
			cur_v_q       <= '0;
			marks_q       <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			sp_q          <= '0;
			issue_q       <= '0;
			scan_valid_s1 <= 1'b0;
			scan_i_s1     <= '0;
		end else begin
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_search && start_ok) begin
						marks_q <= '0;
						n_q     <= n_eff;
						cur_v_q <= vertex;
						dfs_q   <= (mode == MODE_DFS);
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (dfs_q) begin
						sp_q    <= SPW'(1);
						state_q <= ST_NEXT;
					end else if (res_st.room) begin
						marks_q[cur_v_q] <= 1'b1;
						head_q           <= '0;
						tail_q           <= CNT_W'(1);
						state_q          <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (dfs_q) begin
						if (sp_q != '0) begin
							sp_q    <= sp_dec;
							state_q <= ST_POP;
						end else begin
							state_q <= ST_FLUSH;
						end
					end else if (head_q < tail_q) begin
						cur_v_q       <= queue_q[head_q[VW-1:0]];
						head_q        <= head_q + CNT_W'(1);
						issue_q       <= '0;
						scan_valid_s1 <= 1'b0;
						state_q       <= ST_SCAN;
					end else begin
						state_q <= ST_FLUSH;
					end
				end
				ST_POP: begin
					if (marks_q[pop_v]) begin
						state_q <= ST_NEXT;
					end else if (res_st.room) begin
						marks_q[pop_v] <= 1'b1;
						cur_v_q        <= pop_v;
						issue_q        <= '0;
						scan_valid_s1  <= 1'b0;
						state_q        <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!freeze) begin
						scan_valid_s1 <= issue_go;
						if (issue_go) begin
							scan_i_s1 <= issue_q[VW-1:0];
							issue_q   <= issue_q + CNT_W'(1);
						end
						if (hit && !dfs_q) begin
							marks_q[scan_i_s1] <= 1'b1;
							tail_q             <= tail_q + CNT_W'(1);
						end
						if (push) begin
							sp_q <= sp_q + SPW'(1);
						end
						if (scan_done) begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_FLUSH: begin
					if (res_st.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// queue entries carry no reset
	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_q[q_waddr] <= q_wdata;
		end
	end

	adjtrav_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_VERTICES)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (row_bits),
		.re    (issue_go),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	adjtrav_ram #(
		.WIDTH (VW),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (pop_v)
	);

	adjtrav_result u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (res_req),
		.status         (res_st),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.visited_vertex (visited_vertex),
		.last           (last)
	);

	`AT_ASSERT(a_scan_vertex_marked, (state_q == ST_SCAN) |-> marks_q[cur_v_q],
		"scanning a vertex that is not marked")
	`AT_ASSERT(a_idle_no_pending, (state_q == ST_IDLE) |-> !res_st.pend_valid,
		"result held back while idle")
	`AT_ASSERT(a_queue_order, head_q <= tail_q, "queue head passed tail")
	`AT_ASSERT(a_stack_bound, sp_q <= SPW'(STACK_DEPTH), "stack pointer beyond depth")

endmodule
